/* rtl/core/assert_macros.svh */
// Assertion macros shared by the latency averager RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

/* rtl/core/ksl_pkg.sv */
// Shared types and codes for the keyed start/confirm latency averager.
// No dependencies.
package ksl_pkg;
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_CONFIRM = 2'd1;
  localparam logic [1:0] MODE_REPORT  = 2'd2;
  localparam logic [1:0] MODE_RSVD    = 2'd3;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_MATCHED  = 3'd1;
  localparam logic [2:0] ST_NO_START = 3'd2;
  localparam logic [2:0] ST_NONPOS   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_REPORTED = 3'd5;
  localparam logic [2:0] ST_SKIPPED  = 3'd6;

  localparam int unsigned DIV_BITS = 64;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_READ, S_DIV, S_DONE
  } ksl_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

/* rtl/core/ksl_div.sv */
// Restoring divider, one quotient bit per cycle, used for report averages.
// Depends on ksl_pkg and assert_macros.svh.
module ksl_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        dividend,
  input  logic [31:0]        divisor,
  output ksl_pkg::div_ctl_t  ctl,
  output logic [63:0]        quotient
);
  import ksl_pkg::*;
  `include "assert_macros.svh"

  logic [6:0]  cnt;
  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic        busy;
  logic        done;
  logic [32:0] trial;
  logic [32:0] sub;

  assign trial = {rem[31:0], quo[63]};
  assign sub   = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 7'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'(DIV_BITS);
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // shift one dividend bit into the remainder, keep it if it fits
        if (!sub[32]) begin
          rem <= sub;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) busy <= 1'b0;
      end
    end
  end

  assign ctl = '{start: start, busy: busy, done: done};
  assign quotient = quo;

  `CHK_IMPL(a_done_not_busy, clk, rst, done, !busy, "divider done while busy")
  `CHK_NEXT(a_start_busy, clk, rst, start, busy, "divider did not start")
  `CHK_IMPL(a_cnt_range, clk, rst, busy, cnt != 7'd0, "divider count ran out")
endmodule

/* rtl/core/keyed_start_confirm_latency_averager.sv */
// Top level: key table, per-key start FIFOs, counters and report sequencer.
// Depends on ksl_pkg, ksl_div and assert_macros.svh.
//
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | mode, key, time_us
// out     | out | out_valid/out_ready | status, latency_us, avg_latency_us, report_count
// cfg     | in  | cfg_we              | cfg_data (report_interval_us)
//
// Start, skipped reports and ignored modes pass through key match, slot read, update and
// result; confirm adds a step to finish the latency from the read slot.
// A report with matches to average waits in S_DIV for the serial divider.
// Reset is synchronous and clears table valid bits, fill counts and counters.
// in_ready stays low while an item is in work or its result waits on out_ready.
module keyed_start_confirm_latency_averager #(
  parameter int TABLE_ENTRIES = 16,
  parameter int FIFO_DEPTH    = 8,
  parameter int KEY_BITS      = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [63:0] key,
  input  logic [63:0] time_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] latency_us,
  output logic [63:0] avg_latency_us,
  output logic [31:0] report_count,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);
  import ksl_pkg::*;
  `include "assert_macros.svh"

  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int MD = TABLE_ENTRIES * FIFO_DEPTH;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;

  ksl_state_t state, state_next;

  logic [31:0]         interval;
  logic [KEY_BITS-1:0] tags [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_e;
  logic [FW-1:0]       head [TABLE_ENTRIES];
  logic [CW-1:0]       fill [TABLE_ENTRIES];
  logic [63:0]         slots [MD];
  logic [63:0]         rd_data;

  logic [1:0]          r_mode;
  logic [KEY_BITS-1:0] r_key;
  logic [63:0]         r_time;
  logic                hit, has_free;
  logic [EW-1:0]       hit_idx, free_idx, ent;
  logic                ent_hit;
  logic [63:0]         sum;
  logic [31:0]         cnt;
  logic [63:0]         last_t;
  logic [63:0]         pub_avg;
  logic [31:0]         pub_cnt;
  logic                div_start;
  div_ctl_t            dctl;
  logic [63:0]         quo;

  // parallel tag match and lowest free entry
  always_comb begin
    hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_e[i] && tags[i] == r_key) begin
        hit = 1'b1; hit_idx = EW'(i);
      end
      if (!valid_e[i]) begin
        has_free = 1'b1; free_idx = EW'(i);
      end
    end
  end

  logic [FW:0]   slot_sum;
  logic [FW-1:0] tail;
  logic [AW-1:0] rd_addr;
  always_comb begin
    slot_sum = {1'b0, head[ent]} + (FW+1)'(fill[ent]);
    tail = (slot_sum >= (FW+1)'(FIFO_DEPTH)) ? FW'(slot_sum - (FW+1)'(FIFO_DEPTH))
                                             : FW'(slot_sum);
    rd_addr = AW'(ent * FIFO_DEPTH + head[ent]);
  end

  logic [63:0] d;
  logic        ovf;
  assign d   = r_time - rd_data;
  assign ovf = sum > ~d;

  always_ff @(posedge clk) begin
    if (state == S_READ) rd_data <= slots[rd_addr];
    if (state == S_READ && r_mode == MODE_START && !(ent_hit && fill[ent] == CW'(FIFO_DEPTH))
        && (ent_hit || has_free))
      slots[AW'(ent * FIFO_DEPTH + (ent_hit ? tail : FW'(0)))] <= r_time;
  end

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = (in_valid) ? S_LOOK : S_IDLE;
      S_LOOK:  state_next = S_READ;
      S_READ:  state_next = (r_mode == MODE_CONFIRM || div_start) ? S_DIV : S_DONE;
      S_DIV:   state_next = (dctl.busy || div_start) ? S_DIV : S_DONE;
      S_DONE:  state_next = (out_ready) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_DONE);
  end

  assign avg_latency_us = pub_avg;
  assign report_count   = pub_cnt;

  logic report_go;
  assign report_go = (last_t == 64'd0) || ((r_time - last_t) >= {32'd0, interval});

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      interval <= 32'd1000000;
      valid_e  <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        head[i] <= '0; fill[i] <= '0;
      end
      sum <= '0; cnt <= '0; last_t <= '0; pub_avg <= '0; pub_cnt <= '0;
      div_start <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= (state == S_LOOK) && (r_mode == MODE_REPORT) && report_go
                   && (cnt != 32'd0);
      if (cfg_we) interval <= cfg_data;
      if (state == S_IDLE && in_valid) begin
        r_mode <= mode; r_key <= key[KEY_BITS-1:0]; r_time <= time_us;
        latency_us <= '0;
      end
      if (state == S_LOOK) begin
        ent_hit <= hit;
        ent     <= hit ? hit_idx : free_idx;
        if (r_mode == MODE_REPORT) begin
          if (!report_go) status <= ST_SKIPPED;
          else begin
            status <= ST_REPORTED;
            last_t <= r_time;
            if (cnt != 32'd0) pub_cnt <= cnt;
            else sum <= '0;
          end
        end else if (r_mode != MODE_START && r_mode != MODE_CONFIRM) begin
          status <= ST_SKIPPED;
        end
      end
      if (state == S_READ) begin
        if (r_mode == MODE_START) begin
          if (!ent_hit && !has_free) status <= ST_FULL;
          else if (ent_hit && fill[ent] == CW'(FIFO_DEPTH)) status <= ST_FULL;
          else begin
            status <= ST_STORED;
            if (!ent_hit) begin
              valid_e[ent] <= 1'b1; tags[ent] <= r_key;
              head[ent] <= '0; fill[ent] <= CW'(1);
            end else fill[ent] <= fill[ent] + CW'(1);
          end
        end else if (r_mode == MODE_CONFIRM) begin
          if (!ent_hit) status <= ST_NO_START;
          else begin
            fill[ent] <= fill[ent] - CW'(1);
            if (fill[ent] == CW'(1)) begin
              valid_e[ent] <= 1'b0; head[ent] <= '0;
            end else begin
              head[ent] <= (head[ent] == FW'(FIFO_DEPTH - 1)) ? '0 : head[ent] + FW'(1);
            end
          end
        end
      end
      // confirm finish: in S_DIV with memory data ready
      if (state == S_DIV && r_mode == MODE_CONFIRM && ent_hit && !dctl.busy && !div_start) begin
        if (r_time <= rd_data) status <= ST_NONPOS;
        else begin
          status     <= ST_MATCHED;
          latency_us <= d;
          sum        <= ovf ? '1 : sum + d;
          if (cnt != '1) cnt <= cnt + 32'd1;
        end
      end
      if (dctl.done) begin
        pub_avg <= quo; sum <= '0; cnt <= '0;
      end
    end
  end

  // report needs the divider; route it through S_DIV too
  ksl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum), .divisor(cnt),
    .ctl(dctl), .quotient(quo)
  );

  `CHK_IMPL(a_ready_out, clk, rst, in_ready, !out_valid, "ready while result pending")
  `CHK_IMPL(a_div_phase, clk, rst, dctl.busy, state == S_DIV, "divider busy outside divide")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
endmodule

/* verif/latency_scoreboard.sv */
// Checker for the keyed start/confirm latency averager: watches both channels,
// predicts each result from the accepted input beats and compares field by field.
// Depends on ksl_pkg.
module latency_scoreboard
  import ksl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [63:0] key,
  input  logic [63:0] time_us,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [63:0] latency_us,
  input  logic [63:0] avg_latency_us,
  input  logic [31:0] report_count,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  localparam int ENTRIES = 16;
  localparam int DEPTH   = 8;
  localparam int QDEPTH  = 64;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] latency;
    logic [63:0] avg;
    logic [31:0] count;
  } result_t;

  result_t     awaited_results [QDEPTH];
  logic [5:0]  wr_ptr;
  logic [5:0]  rd_ptr;
  int          held;
  logic [31:0] interval;
  logic [63:0] tags [ENTRIES];
  logic        used [ENTRIES];
  logic [63:0] starts [ENTRIES][DEPTH];
  int          head [ENTRIES];
  int          fill [ENTRIES];
  logic [63:0] lat_sum;
  logic [31:0] match_cnt;
  logic [63:0] last_report;
  logic [63:0] pub_avg;
  logic [31:0] pub_count;

  assign pending = held;

  function automatic int lookup(logic [63:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (used[i] && tags[i] == k) return i;
    return -1;
  endfunction

  function automatic result_t advance_averager(logic [1:0] m, logic [63:0] k,
                                               logic [63:0] t);
    result_t r;
    int e;
    logic [63:0] st;
    logic [63:0] d;
    r = '0;
    case (m)
      MODE_START: begin
        e = lookup(k);
        r.status = ST_STORED;
        if (e < 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (!used[i] && e < 0) e = i;
          if (e >= 0) begin
            used[e] = 1'b1;
            tags[e] = k;
            head[e] = 0;
            fill[e] = 0;
          end
        end
        if (e < 0 || fill[e] >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          starts[e][(head[e] + fill[e]) % DEPTH] = t;
          fill[e]++;
        end
      end
      MODE_CONFIRM: begin
        e = lookup(k);
        if (e < 0 || fill[e] == 0) begin
          r.status = ST_NO_START;
        end else begin
          st = starts[e][head[e]];
          head[e] = (head[e] + 1) % DEPTH;
          fill[e]--;
          if (fill[e] == 0) begin
            used[e] = 1'b0;
            head[e] = 0;
          end
          if (t <= st) begin
            r.status = ST_NONPOS;
          end else begin
            d = t - st;
            lat_sum = (lat_sum > ~64'd0 - d) ? ~64'd0 : lat_sum + d;
            if (match_cnt != '1) match_cnt++;
            r.latency = d;
            r.status = ST_MATCHED;
          end
        end
      end
      MODE_REPORT: begin
        if (last_report != 0 && t - last_report < {32'd0, interval}) begin
          r.status = ST_SKIPPED;
        end else begin
          if (match_cnt > 0) begin
            pub_avg = lat_sum / {32'd0, match_cnt};
            pub_count = match_cnt;
          end
          lat_sum = 0;
          match_cnt = 0;
          last_report = t;
          r.status = ST_REPORTED;
        end
      end
      default: r.status = ST_SKIPPED;
    endcase
    r.avg = pub_avg;
    r.count = pub_count;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
      interval = 32'd1000000;
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] = 1'b0;
        head[i] = 0;
        fill[i] = 0;
      end
      lat_sum = 0;
      match_cnt = 0;
      last_report = 0;
      pub_avg = 0;
      pub_count = 0;
      wr_ptr = '0;
      rd_ptr = '0;
      held = 0;
    end else begin
      if (cfg_we) interval = cfg_data;
      if (in_valid && in_ready) begin
        awaited_results[wr_ptr] = advance_averager(mode, key, time_us);
        wr_ptr = wr_ptr + 6'd1;
        held++;
      end
      if (out_valid && out_ready) begin
        if (held == 0) begin
          $error("result beat with nothing expected");
          bad++;
        end else begin
          want = awaited_results[rd_ptr];
          rd_ptr = rd_ptr + 6'd1;
          held--;
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            bad++;
          end
          if (latency_us !== want.latency) begin
            $error("latency_us: expected %0d, got %0d", want.latency, latency_us);
            bad++;
          end
          if (avg_latency_us !== want.avg) begin
            $error("avg_latency_us: expected %0d, got %0d", want.avg, avg_latency_us);
            bad++;
          end
          if (report_count !== want.count) begin
            $error("report_count: expected %0d, got %0d", want.count, report_count);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end
endmodule

/* verif/keyed_start_confirm_latency_averager_tb.sv */
// Testbench top for the keyed start/confirm latency averager: directed and
// random start/confirm/report traffic with random stalls, plus the verdict.
// Depends on ksl_pkg, the block and latency_scoreboard.
module keyed_start_confirm_latency_averager_tb;
  import ksl_pkg::*;

  localparam int LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [63:0] key;
  logic [63:0] time_us;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [63:0] latency_us;
  logic [63:0] avg_latency_us;
  logic [31:0] report_count;
  logic        cfg_we;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          cycles;
  logic        calm;
  logic [63:0] clock_us;
  logic [63:0] key_pool [6];

  keyed_start_confirm_latency_averager DUT (.*);

  latency_scoreboard checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver stalls in bursts until the calm tail of the run.
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Hold valid across back-to-back beats; drop it only for an idle burst.
  task automatic send_beat(logic [1:0] m, logic [63:0] k, logic [63:0] t);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    key <= k;
    time_us <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic drain_and_set(logic [31:0] value);
    drain();
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [1:0]  m;
    logic [63:0] k;
    int          pick;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_START;
    key = '0;
    time_us = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, no-start, nonpositive, overflow, zero-match report.
    send_beat(MODE_CONFIRM, 64'd5, 64'd10);
    send_beat(MODE_REPORT, 64'd0, 64'd0);
    send_beat(MODE_REPORT, 64'd0, 64'd0);
    send_beat(MODE_START, '1, 64'd0);
    send_beat(MODE_CONFIRM, '1, '1);
    send_beat(MODE_START, 64'd7, '1);
    send_beat(MODE_CONFIRM, 64'd7, 64'd3);
    send_beat(MODE_START, 64'd7, 64'd100);
    send_beat(MODE_CONFIRM, 64'd7, 64'd100);
    for (int i = 0; i < 9; i++) send_beat(MODE_START, 64'd9, 64'd50 + i);
    send_beat(MODE_RSVD, '1, '1);
    send_beat(MODE_REPORT, 64'd0, 64'd2000000);
    send_beat(MODE_REPORT, 64'd0, 64'd2000001);
    send_beat(MODE_REPORT, 64'd0, 64'd5);

    drain_and_set(32'd0);
    for (int i = 0; i < 17; i++) send_beat(MODE_START, 64'h100 + i, 64'd1000);
    for (int i = 0; i < 16; i++) send_beat(MODE_CONFIRM, 64'h100 + i, 64'd1000 + i);
    for (int i = 0; i < 8; i++) send_beat(MODE_CONFIRM, 64'd9, 64'd200);
    send_beat(MODE_REPORT, 64'd0, 64'd1);

    // Random phases under several report intervals.
    clock_us = 64'd1000;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1) drain_and_set('1);
      if (phase == 2) drain_and_set($urandom_range(1, 400));
      if (phase == 3) begin
        drain_and_set(32'd1000000);
        calm = 1'b1;
      end
      for (int j = 0; j < 6; j++) key_pool[j] = wide_rand();
      for (int n = 0; n < 122; n++) begin
        pick = $urandom_range(0, 99);
        clock_us = clock_us + $urandom_range(0, 300);
        k = key_pool[$urandom_range(0, 5)];
        if (pick < 45) m = MODE_START;
        else if (pick < 85) m = MODE_CONFIRM;
        else if (pick < 95) m = MODE_REPORT;
        else m = MODE_RSVD;
        if (pick >= 97) k = wide_rand();
        if (pick == 50 || pick == 10) send_beat(m, k, wide_rand());
        else send_beat(m, k, clock_us);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
